>>> src/psg_pkg.sv
package psg_pkg;

    localparam int NUM_REGS       = 16;
    localparam int REG_IDX_W      = 4;
    localparam int TONE_W         = 12;
    localparam int NOISE_PER_W    = 5;
    localparam int NOISE_W        = 17;
    localparam int NUM_CHANS      = 3;
    localparam int NOISE_PER_REG  = 6;

    localparam logic [NOISE_W-1:0] NOISE_SEED = 17'h1ffff;

    typedef enum logic [1:0] {
        FUNC_SELECT = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] data;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0]           read_data;
        logic [REG_IDX_W-1:0] selected_index;
        logic                 tone_level_a;
        logic                 tone_level_b;
        logic                 tone_level_c;
        logic                 noise_out;
    } res_word_t;

endpackage

>>> src/psg_tone_noise_generator_top.sv
// three-channel tone and noise generator with a sixteen-byte register file
// cmd channel: a word carries func and data; func selects a register, writes
//   the selected register, reads a register by index, or advances one master tick
// res channel: one word per cmd word, in order, carrying the read byte (zero
//   unless a read), the selected register number, the three square levels and
//   the noise bit as they stand after that cmd word
// a word is taken when valid is high and stall is low
// a taken cmd word reaches res valid through the cmd register, then the result
//   register; throughput one word per cycle while res is not stalled, set by the
//   single combinational pass between the two registers
// every TICKS_PER_CLOCK master ticks make one chip clock, which steps the tone
//   and noise counters
// reset clears the register file, select, prescaler and counters, loads the
//   noise shift register with all ones and drops both valids
// a stall on res holds the result; cmd stall rises only while a cmd word is
//   waiting and the result register is full and stalled
module psg_tone_noise_generator_top #(
    parameter int TICKS_PER_CLOCK = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  psg_pkg::cmd_word_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output psg_pkg::res_word_t res
);

    localparam int PHASE_W = (TICKS_PER_CLOCK > 1) ? $clog2(TICKS_PER_CLOCK) : 1;

    logic                             cmd_valid_reg;
    psg_pkg::cmd_word_t               cmd_word_reg;
    logic                             res_valid_reg;
    psg_pkg::res_word_t               res_word_reg;
    logic [psg_pkg::REG_IDX_W-1:0]    sel_reg;
    logic [psg_pkg::REG_IDX_W-1:0]    sel_next;
    logic [7:0]                       regs_reg [psg_pkg::NUM_REGS];
    logic [PHASE_W-1:0]               phase_reg;
    logic [PHASE_W-1:0]               phase_next;
    logic [PHASE_W:0]                 phase_inc;
    logic                             advance;
    logic                             fire;
    logic                             chip_en;
    logic [7:0]                       rd;
    logic [psg_pkg::NUM_CHANS-1:0]    levels_next;
    logic                             noise_next;
    psg_pkg::res_word_t               res_next;

    assign advance   = !res_valid_reg || !res_stall;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign fire      = cmd_valid_reg && advance;
    assign res_valid = res_valid_reg;
    assign res       = res_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            cmd_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_word_reg <= cmd;
        end
    end

    always_comb
    begin
        sel_next   = sel_reg;
        phase_next = phase_reg;
        phase_inc  = {1'b0, phase_reg} + (PHASE_W + 1)'(1);
        chip_en    = 1'b0;
        rd         = '0;
        if (fire)
        begin
            case (cmd_word_reg.func)
                psg_pkg::FUNC_SELECT:
                begin
                    sel_next = cmd_word_reg.data[psg_pkg::REG_IDX_W-1:0];
                end
                psg_pkg::FUNC_TICK:
                begin
                    if (phase_inc >= (PHASE_W + 1)'(TICKS_PER_CLOCK))
                    begin
                        phase_next = '0;
                        chip_en    = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_inc[PHASE_W-1:0];
                    end
                end
                psg_pkg::FUNC_READ:
                begin
                    rd = regs_reg[cmd_word_reg.data[psg_pkg::REG_IDX_W-1:0]];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            phase_reg <= '0;
            for (int i = 0; i < psg_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            sel_reg   <= sel_next;
            phase_reg <= phase_next;
            if (fire && cmd_word_reg.func == psg_pkg::FUNC_WRITE)
            begin
                regs_reg[sel_reg] <= cmd_word_reg.data;
            end
        end
    end

    for (genvar ch = 0; ch < psg_pkg::NUM_CHANS; ch++)
    begin : g_tone
        psg_tone_chan u_tone (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (chip_en),
            .period     ({regs_reg[2*ch+1][3:0], regs_reg[2*ch]}),
            .level_next (levels_next[ch])
        );
    end

    psg_noise u_noise (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (chip_en),
        .period     (regs_reg[psg_pkg::NOISE_PER_REG][psg_pkg::NOISE_PER_W-1:0]),
        .noise_next (noise_next)
    );

    always_comb
    begin
        res_next.read_data      = rd;
        res_next.selected_index = sel_next;
        res_next.tone_level_a   = levels_next[0];
        res_next.tone_level_b   = levels_next[1];
        res_next.tone_level_c   = levels_next[2];
        res_next.noise_out      = noise_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_word_reg <= res_next;
        end
    end

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (res_valid && res_stall))
        else $error("cmd stall without a stalled result");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (PHASE_W + 1)'(phase_reg) < (PHASE_W + 1)'(TICKS_PER_CLOCK))
        else $error("prescaler phase out of range");

    a_select_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_word_reg.func == psg_pkg::FUNC_SELECT)
        |=> (sel_reg == $past(cmd_word_reg.data[psg_pkg::REG_IDX_W-1:0])))
        else $error("register select not taken");

    a_result_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid)
        else $error("result missing after accepted cmd word");
`endif

endmodule

>>> src/psg_tone_chan.sv
module psg_tone_chan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [psg_pkg::TONE_W-1:0]  period,
    output logic                        level_next
);

    logic [psg_pkg::TONE_W-1:0] count_reg;
    logic [psg_pkg::TONE_W-1:0] count_next;
    logic                       level_reg;
    logic [psg_pkg::TONE_W-1:0] eff_period;
    logic [psg_pkg::TONE_W-1:0] loaded;
    logic [psg_pkg::TONE_W-1:0] dec;

    always_comb
    begin
        eff_period = (period == '0) ? psg_pkg::TONE_W'(1) : period;
        loaded     = (count_reg == '0 || count_reg > eff_period) ? eff_period : count_reg;
        dec        = loaded - psg_pkg::TONE_W'(1);
        count_next = count_reg;
        level_next = level_reg;
        if (step)
        begin
            if (dec == '0)
            begin
                count_next = eff_period;
                level_next = ~level_reg;
            end
            else
            begin
                count_next = dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

>>> src/psg_noise.sv
module psg_noise (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [psg_pkg::NOISE_PER_W-1:0]  period,
    output logic                             noise_next
);

    logic [psg_pkg::NOISE_PER_W-1:0] count_reg;
    logic [psg_pkg::NOISE_PER_W-1:0] count_next;
    logic [psg_pkg::NOISE_W-1:0]     shift_reg;
    logic [psg_pkg::NOISE_W-1:0]     shift_next;
    logic                            bit_reg;
    logic [psg_pkg::NOISE_PER_W-1:0] eff_period;
    logic [psg_pkg::NOISE_PER_W-1:0] loaded;
    logic [psg_pkg::NOISE_PER_W-1:0] dec;

    always_comb
    begin
        eff_period = (period == '0) ? psg_pkg::NOISE_PER_W'(1) : period;
        loaded     = (count_reg == '0 || count_reg > eff_period) ? eff_period : count_reg;
        dec        = loaded - psg_pkg::NOISE_PER_W'(1);
        count_next = count_reg;
        shift_next = shift_reg;
        noise_next = bit_reg;
        if (step)
        begin
            if (dec == '0)
            begin
                count_next = eff_period;
                shift_next = {shift_reg[0] ^ shift_reg[3], shift_reg[psg_pkg::NOISE_W-1:1]};
                noise_next = shift_reg[1];
            end
            else
            begin
                count_next = dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            shift_reg <= psg_pkg::NOISE_SEED;
            bit_reg   <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            shift_reg <= shift_next;
            bit_reg   <= noise_next;
        end
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS          = 16;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int WORDS_PER_PHASE = 250;
    localparam int HOLD_CYCLES    = 64;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int N_DIR          = 25;

    localparam int TX_IDLE_PCT [4] = '{0, 86, 0, 33};
    localparam int RX_STALL_PCT [4] = '{0, 0, 86, 33};

    typedef struct packed {
        psg_pkg::cmd_word_t w;
        bit                 known;
        psg_pkg::res_word_t want;
    } stim_row_t;

    localparam psg_pkg::res_word_t AT_SEL6 =
        psg_pkg::res_word_t'{8'h00, 4'h6, 1'b0, 1'b0, 1'b0, 1'b1};

    // reset state, select and write extremes, read index masking, one full prescaler pass
    localparam stim_row_t DIR_ROWS [N_DIR] = '{
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_READ,   8'h00}, 1'b1,
          psg_pkg::res_word_t'{8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_SELECT, 8'hff}, 1'b1,
          psg_pkg::res_word_t'{8'h00, 4'hf, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_WRITE,  8'hff}, 1'b1,
          psg_pkg::res_word_t'{8'h00, 4'hf, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_READ,   8'hff}, 1'b1,
          psg_pkg::res_word_t'{8'hff, 4'hf, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_READ,   8'hf0}, 1'b1,
          psg_pkg::res_word_t'{8'h00, 4'hf, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_SELECT, 8'h06}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_WRITE,  8'he0}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_READ,   8'h36}, 1'b1,
          psg_pkg::res_word_t'{8'he0, 4'h6, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'h00}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'hff}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'h00}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'hff}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'h00}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'hff}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'h00}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'hff}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'h00}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'hff}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'h00}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'hff}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'h00}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'hff}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'h00}, 1'b1, AT_SEL6},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK,   8'hff}, 1'b0,
          psg_pkg::res_word_t'('0)},
        '{psg_pkg::cmd_word_t'{psg_pkg::FUNC_READ,   8'h0f}, 1'b0,
          psg_pkg::res_word_t'('0)}
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    psg_pkg::cmd_word_t cmd       = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    psg_pkg::res_word_t res;

    // predictor state
    logic [7:0]                  psg_regs [psg_pkg::NUM_REGS] = '{default: 8'h00};
    logic [3:0]                  sel_idx    = '0;
    logic [7:0]                  phase      = '0;
    logic [psg_pkg::TONE_W-1:0]  tone_cnt [psg_pkg::NUM_CHANS] = '{default: '0};
    logic [2:0]                  tone_lvl   = '0;
    logic [4:0]                  noise_cnt  = '0;
    logic [psg_pkg::NOISE_W-1:0] shift_state = psg_pkg::NOISE_SEED;
    logic                        noise_lvl  = 1'b1;

    psg_pkg::res_word_t pending_res [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_reqs    = 0;
    int holds_done   = 0;
    int hold_left    = 0;
    int mismatch_cnt = 0;
    int words_sent   = 0;
    int reads_sent   = 0;
    int results_seen = 0;
    int chip_clocks  = 0;
    int tone_flips   = 0;
    int lfsr_steps   = 0;
    int cycle_cnt    = 0;

    psg_tone_noise_generator_top #(
        .TICKS_PER_CLOCK(TICKS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic psg_pkg::res_word_t predict_psg(input psg_pkg::cmd_word_t w);
        psg_pkg::res_word_t         r;
        logic [psg_pkg::TONE_W-1:0] per;
        logic [4:0]                 np;
        logic                       fb;
        r = '0;
        case (w.func)
            psg_pkg::FUNC_SELECT: sel_idx = w.data[3:0];
            psg_pkg::FUNC_WRITE:  psg_regs[sel_idx] = w.data;
            psg_pkg::FUNC_TICK:
            begin
                if (int'(phase) + 1 >= TICKS)
                begin
                    phase = '0;
                    chip_clocks++;
                    for (int ch = 0; ch < psg_pkg::NUM_CHANS; ch++)
                    begin
                        per = {psg_regs[2 * ch + 1][3:0], psg_regs[2 * ch]};
                        if (per == '0)
                            per = psg_pkg::TONE_W'(1);
                        if (tone_cnt[ch] == '0 || tone_cnt[ch] > per)
                            tone_cnt[ch] = per;
                        tone_cnt[ch] = tone_cnt[ch] - 1'b1;
                        if (tone_cnt[ch] == '0)
                        begin
                            tone_cnt[ch] = per;
                            tone_lvl[ch] = ~tone_lvl[ch];
                            tone_flips++;
                        end
                    end
                    np = psg_regs[psg_pkg::NOISE_PER_REG][4:0];
                    if (np == '0)
                        np = 5'd1;
                    if (noise_cnt == '0 || noise_cnt > np)
                        noise_cnt = np;
                    noise_cnt = noise_cnt - 1'b1;
                    if (noise_cnt == '0)
                    begin
                        fb = shift_state[0] ^ shift_state[3];
                        noise_cnt = np;
                        shift_state = {fb, shift_state[psg_pkg::NOISE_W-1:1]};
                        noise_lvl = shift_state[0];
                        lfsr_steps++;
                    end
                end
                else
                    phase = phase + 8'd1;
            end
            default: r.read_data = psg_regs[w.data[3:0]];
        endcase
        r.selected_index = sel_idx;
        r.tone_level_a   = tone_lvl[0];
        r.tone_level_b   = tone_lvl[1];
        r.tone_level_c   = tone_lvl[2];
        r.noise_out      = noise_lvl;
        return r;
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_word(input psg_pkg::cmd_word_t w, input bit known = 1'b0,
                             input psg_pkg::res_word_t want = '0);
        psg_pkg::res_word_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        r = predict_psg(w);
        pending_res.push_back(known ? want : r);
        words_sent++;
        if (w.func == psg_pkg::FUNC_READ)
            reads_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : res_check
        psg_pkg::res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (pending_res.size() == 0)
            begin
                $error("result word %0h with nothing expected", res);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_res.pop_front();
                check_field("read_data", 32'(want.read_data), 32'(res.read_data));
                check_field("selected_index", 32'(want.selected_index),
                            32'(res.selected_index));
                check_field("tone_level_a", 32'(want.tone_level_a), 32'(res.tone_level_a));
                check_field("tone_level_b", 32'(want.tone_level_b), 32'(res.tone_level_b));
                check_field("tone_level_c", 32'(want.tone_level_c), 32'(res.tone_level_c));
                check_field("noise_out", 32'(want.noise_out), 32'(res.noise_out));
            end
        end
    end

    // receiver stall, with a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (holds_done != hold_reqs)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_cnt, pending_res.size());
            $display("** psg_tone_noise_generator_top: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         ph;
        int         stop_at;
        int         kind;
        int         ch;
        int         len;
        logic [7:0] lo;
        logic [7:0] hi;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_word(DIR_ROWS[i].w, DIR_ROWS[i].known, DIR_ROWS[i].want);

        for (ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = TX_IDLE_PCT[ph];
            rx_stall_pct = RX_STALL_PCT[ph];
            if (ph == 0)
                hold_reqs++;
            stop_at = words_sent + WORDS_PER_PHASE;
            while (words_sent < stop_at)
            begin
                kind = $urandom_range(99);
                if (kind < 25)
                begin
                    // program a tone period, mostly short
                    ch = $urandom_range(psg_pkg::NUM_CHANS - 1);
                    lo = ($urandom_range(9) < 7) ? 8'($urandom_range(7)) : 8'($urandom);
                    hi = {4'($urandom), ($urandom_range(9) < 8) ? 4'h0 : 4'($urandom)};
                    send_word(psg_pkg::cmd_word_t'{psg_pkg::FUNC_SELECT,
                                                   {4'($urandom), 4'(2 * ch)}});
                    send_word(psg_pkg::cmd_word_t'{psg_pkg::FUNC_WRITE, lo});
                    send_word(psg_pkg::cmd_word_t'{psg_pkg::FUNC_SELECT,
                                                   {4'($urandom), 4'(2 * ch + 1)}});
                    send_word(psg_pkg::cmd_word_t'{psg_pkg::FUNC_WRITE, hi});
                end
                else if (kind < 35)
                begin
                    lo = ($urandom_range(4) > 0) ? {3'($urandom), 5'($urandom_range(3))}
                                                 : 8'($urandom);
                    send_word(psg_pkg::cmd_word_t'{psg_pkg::FUNC_SELECT,
                                          {4'($urandom), 4'(psg_pkg::NOISE_PER_REG)}});
                    send_word(psg_pkg::cmd_word_t'{psg_pkg::FUNC_WRITE, lo});
                end
                else if (kind < 45)
                    send_word(psg_pkg::cmd_word_t'{psg_pkg::FUNC_READ, 8'($urandom)});
                else if (kind < 52)
                    send_word(psg_pkg::cmd_word_t'{psg_pkg::func_t'($urandom_range(3)),
                                                   8'($urandom)});
                else
                begin
                    len = $urandom_range(48, 8);
                    repeat (len)
                        send_word(psg_pkg::cmd_word_t'{psg_pkg::FUNC_TICK, 8'($urandom)});
                end
            end
            // let every result come home before the next phase
            cmd_valid <= 1'b0;
            while (pending_res.size() != 0)
                @(posedge clk);
            @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d command words (%0d reads) sent, %0d result words checked",
                 words_sent, reads_sent, results_seen);
        $display("%0d chip clocks, %0d tone level changes, %0d noise shifts",
                 chip_clocks, tone_flips, lfsr_steps);
        if (mismatch_cnt == 0 && pending_res.size() == 0)
            $display("** psg_tone_noise_generator_top: PASSED **");
        else
            $display("** psg_tone_noise_generator_top: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
src/psg_pkg.sv
src/psg_tone_chan.sv
src/psg_noise.sv
src/psg_tone_noise_generator_top.sv
tb/sv/testbench.sv
